/* hw/rtl/y86f_pkg.sv */
// Shared types, codes and decode helpers for the Y86-64 fetch stage.
package y86f_pkg;

    localparam logic       FN_LOAD  = 1'b0;
    localparam logic       FN_FETCH = 1'b1;

    localparam logic [3:0] IC_HALT  = 4'd0;
    localparam logic [3:0] IC_NOP   = 4'd1;
    localparam logic [3:0] IC_RRMOV = 4'd2;
    localparam logic [3:0] IC_IRMOV = 4'd3;
    localparam logic [3:0] IC_RMMOV = 4'd4;
    localparam logic [3:0] IC_MRMOV = 4'd5;
    localparam logic [3:0] IC_OPQ   = 4'd6;
    localparam logic [3:0] IC_JXX   = 4'd7;
    localparam logic [3:0] IC_CALL  = 4'd8;
    localparam logic [3:0] IC_RET   = 4'd9;
    localparam logic [3:0] IC_PUSH  = 4'd10;
    localparam logic [3:0] IC_POP   = 4'd11;

    localparam logic [3:0] NO_REG   = 4'hf;

    localparam logic [1:0] ST_AOK = 2'd0;
    localparam logic [1:0] ST_HLT = 2'd1;
    localparam logic [1:0] ST_INS = 2'd2;
    localparam logic [1:0] ST_ADR = 2'd3;

    typedef struct packed {
        logic        func;
        logic [11:0] load_addr;
        logic [7:0]  load_byte;
        logic [3:0]  mem_icode;
        logic        mem_cond;
        logic [63:0] mem_vala;
        logic [3:0]  wb_icode;
        logic [63:0] wb_valm;
    } t_in;

    typedef struct packed {
        logic [63:0] fetch_pc;
        logic [3:0]  icode;
        logic [3:0]  ifun;
        logic [3:0]  reg_a;
        logic [3:0]  reg_b;
        logic [63:0] val_c;
        logic [63:0] val_p;
        logic [1:0]  status;
        logic [63:0] next_pred_pc;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_FINISH
    } t_state;

    function automatic logic [3:0] f_len(input logic [3:0] icode);
        logic [3:0] len;
        unique case (icode)
            IC_RRMOV, IC_OPQ, IC_PUSH, IC_POP: len = 4'd2;
            IC_IRMOV, IC_RMMOV, IC_MRMOV:      len = 4'd10;
            IC_JXX, IC_CALL:                   len = 4'd9;
            default:                           len = 4'd1;
        endcase
        return len;
    endfunction

    function automatic logic f_has_reg(input logic [3:0] icode);
        return (icode == IC_RRMOV) || (icode == IC_OPQ) || (icode == IC_PUSH) ||
               (icode == IC_POP) || (icode == IC_IRMOV) || (icode == IC_RMMOV) ||
               (icode == IC_MRMOV);
    endfunction

    function automatic logic f_has_const(input logic [3:0] icode);
        return (icode == IC_IRMOV) || (icode == IC_RMMOV) || (icode == IC_MRMOV) ||
               (icode == IC_JXX) || (icode == IC_CALL);
    endfunction

endpackage

/* hw/rtl/y86_pipeline_fetch_stage.sv */
// Y86-64 fetch stage with private byte-wide instruction memory and byte sequencer.
//
// Input channel (i_in_valid / o_in_ready / i_in) carries one request: a load
// writes one instruction memory byte, a fetch reads one instruction.
// Output channel (o_out_valid / i_out_ready / o_out) carries one result per fetch.
// A load leaves the block idle and gives no result; loads beyond MEM_BYTES are dropped.
// A fetch reads its instruction one byte per cycle through the single memory read
// port; one shared 64-bit adder forms every byte address and finally valP.
// A fetch occupies the block from acceptance until its result enters the output
// register; o_in_ready is low meanwhile, so a new request waits for it to finish.
// The result enters the output register from the finish step, which follows the decode
// of the last byte and waits for a free output; the predicted PC is updated at the same edge.
// A stalled receiver holds the result; a following request is still taken, and a
// second fetch waits in its final step until the held result leaves.
// Synchronous reset clears the sequencer, the output valid and the predicted PC;
// the instruction memory is not cleared and must be loaded before it is fetched.
module y86_pipeline_fetch_stage #(
    parameter int MEM_BYTES = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  y86f_pkg::t_in i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output y86f_pkg::t_out o_out
);

    localparam int AW = $clog2(MEM_BYTES);

    logic [7:0] r_mem [MEM_BYTES];

    y86f_pkg::t_state r_state, n_state;

    logic [63:0] r_pc;
    logic [63:0] r_pred;
    logic [3:0]  r_k;
    logic        r_rd_valid;
    logic [3:0]  r_rd_k;
    logic        r_rd_bad;
    logic [7:0]  r_rd_data;
    logic [3:0]  r_icode;
    logic [3:0]  r_ifun;
    logic [3:0]  r_rega;
    logic [3:0]  r_regb;
    logic [63:0] r_valc;
    logic        r_bad;
    y86f_pkg::t_out r_out;
    logic        r_out_valid;

    logic        w_accept;
    logic        w_load;
    logic        w_fetch;
    logic [63:0] w_sel_pc;
    logic [3:0]  w_add_b;
    logic [63:0] w_sum;
    logic        w_addr_bad;
    logic        w_load_ok;
    logic [7:0]  w_byte;
    logic [3:0]  w_icode0;
    logic [3:0]  w_cur_icode;
    logic        w_last;
    logic        w_out_free;
    logic        w_issue;
    logic        w_finish;
    logic [1:0]  w_status;
    logic [63:0] w_next;

    assign w_accept = i_in_valid && o_in_ready;
    assign w_load   = w_accept && (i_in.func == y86f_pkg::FN_LOAD);
    assign w_fetch  = w_accept && (i_in.func == y86f_pkg::FN_FETCH);
    assign w_load_ok = {52'd0, i_in.load_addr} < 64'(MEM_BYTES);

    always_comb begin
        priority if (i_in.mem_icode == y86f_pkg::IC_JXX && !i_in.mem_cond) begin
            w_sel_pc = i_in.mem_vala;
        end else if (i_in.wb_icode == y86f_pkg::IC_RET) begin
            w_sel_pc = i_in.wb_valm;
        end else begin
            w_sel_pc = r_pred;
        end
    end

    // shared address / valP adder
    assign w_add_b    = (r_state == y86f_pkg::S_FINISH) ? y86f_pkg::f_len(r_icode) : r_k;
    assign w_sum      = r_pc + {60'd0, w_add_b};
    assign w_addr_bad = w_sum >= 64'(MEM_BYTES);

    assign w_byte      = r_rd_bad ? 8'd0 : r_rd_data;
    assign w_icode0    = r_rd_bad ? y86f_pkg::IC_NOP : w_byte[7:4];
    assign w_cur_icode = (r_rd_k == 4'd0) ? w_icode0 : r_icode;
    assign w_last      = r_rd_valid &&
                         (r_rd_k == y86f_pkg::f_len(w_cur_icode) - 4'd1);
    assign w_out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            y86f_pkg::S_IDLE: begin
                if (w_fetch) begin
                    n_state = y86f_pkg::S_FETCH;
                end
            end
            y86f_pkg::S_FETCH: begin
                if (w_last) begin
                    n_state = y86f_pkg::S_FINISH;
                end
            end
            y86f_pkg::S_FINISH: begin
                if (w_out_free) begin
                    n_state = y86f_pkg::S_IDLE;
                end
            end
            default: n_state = y86f_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        w_issue    = 1'b0;
        w_finish   = 1'b0;
        unique case (r_state)
            y86f_pkg::S_IDLE:   o_in_ready = 1'b1;
            y86f_pkg::S_FETCH:  w_issue    = !w_last;
            y86f_pkg::S_FINISH: w_finish   = w_out_free;
            default: o_in_ready = 1'b0;
        endcase
    end

    always_comb begin
        priority if (r_bad) begin
            w_status = y86f_pkg::ST_ADR;
        end else if (r_icode >= 4'd12) begin
            w_status = y86f_pkg::ST_INS;
        end else if (r_icode == y86f_pkg::IC_HALT) begin
            w_status = y86f_pkg::ST_HLT;
        end else begin
            w_status = y86f_pkg::ST_AOK;
        end
    end

    assign w_next = (r_icode == y86f_pkg::IC_JXX || r_icode == y86f_pkg::IC_CALL) ?
                    r_valc : w_sum;

    always_ff @(posedge i_clk) begin
        if (w_load && w_load_ok) begin
            r_mem[AW'(i_in.load_addr)] <= i_in.load_byte;
        end
        if (r_state == y86f_pkg::S_FETCH && !w_addr_bad) begin
            r_rd_data <= r_mem[AW'(w_sum)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= y86f_pkg::S_IDLE;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pred      <= 64'd0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= w_issue;
            if (w_finish) begin
                r_out_valid <= 1'b1;
                r_pred      <= w_next;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fetch) begin
            r_pc    <= w_sel_pc;
            r_k     <= 4'd0;
            r_rega  <= y86f_pkg::NO_REG;
            r_regb  <= y86f_pkg::NO_REG;
            r_valc  <= 64'd0;
            r_bad   <= 1'b0;
        end
        if (r_state == y86f_pkg::S_FETCH) begin
            r_k      <= r_k + 4'd1;
            r_rd_k   <= r_k;
            r_rd_bad <= w_addr_bad;
        end
        if (r_state == y86f_pkg::S_FETCH && r_rd_valid) begin
            if (r_rd_bad) begin
                r_bad <= 1'b1;
            end
            if (r_rd_k == 4'd0) begin
                r_icode <= w_icode0;
                r_ifun  <= r_rd_bad ? 4'd0 : w_byte[3:0];
            end else if (r_rd_k == 4'd1 && y86f_pkg::f_has_reg(r_icode)) begin
                r_rega <= w_byte[7:4];
                r_regb <= w_byte[3:0];
            end else if (y86f_pkg::f_has_const(r_icode)) begin
                r_valc <= {w_byte, r_valc[63:8]};
            end
        end
        if (w_finish) begin
            r_out.fetch_pc     <= r_pc;
            r_out.icode        <= r_icode;
            r_out.ifun         <= r_ifun;
            r_out.reg_a        <= r_rega;
            r_out.reg_b        <= r_regb;
            r_out.val_c        <= r_valc;
            r_out.val_p        <= w_sum;
            r_out.status       <= w_status;
            r_out.next_pred_pc <= w_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* sim/y86_pipeline_fetch_stage_chk.sv */
// Request/result monitor and fetch predictor for the Y86-64 fetch stage testbench.
module y86_pipeline_fetch_stage_chk
    import y86f_pkg::*;
#(
    parameter int MEM_BYTES = 4096
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_in  i_in,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_out i_out,
    output int   o_fail_count,
    output int   o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]  imem_copy [MEM_BYTES];
    logic [63:0] pred_pc = '0;
    t_out        fetched_instrs [$];
    int          fails = 0;

    function automatic logic [7:0] imem_byte(input logic [63:0] addr, inout logic bad);
        if (addr >= 64'(MEM_BYTES)) begin
            bad = 1'b1;
            return 8'h00;
        end
        return imem_copy[addr[31:0]];
    endfunction

    function automatic logic [63:0] imem_quad(input logic [63:0] addr, inout logic bad);
        logic [63:0] q;
        q = '0;
        for (int i = 0; i < 8; i++) begin
            q[8*i +: 8] = imem_byte(addr + 64'(i), bad);
        end
        return q;
    endfunction

    function automatic t_out fetch_instr(input t_in rq);
        t_out        r;
        logic [63:0] pc;
        logic [7:0]  b;
        logic        bad;
        logic        legal;
        bad   = 1'b0;
        legal = 1'b1;
        if (rq.mem_icode == IC_JXX && !rq.mem_cond) begin
            pc = rq.mem_vala;
        end else if (rq.wb_icode == IC_RET) begin
            pc = rq.wb_valm;
        end else begin
            pc = pred_pc;
        end
        r          = '0;
        r.fetch_pc = pc;
        r.reg_a    = NO_REG;
        r.reg_b    = NO_REG;
        b = imem_byte(pc, bad);
        if (bad) begin
            r.icode = IC_NOP;
            r.ifun  = 4'h0;
        end else begin
            r.icode = b[7:4];
            r.ifun  = b[3:0];
        end
        case (r.icode)
            IC_HALT, IC_NOP, IC_RET: begin
                r.val_p = pc + 64'd1;
            end
            IC_RRMOV, IC_OPQ, IC_PUSH, IC_POP: begin
                b = imem_byte(pc + 64'd1, bad);
                {r.reg_a, r.reg_b} = b;
                r.val_p = pc + 64'd2;
            end
            IC_IRMOV, IC_RMMOV, IC_MRMOV: begin
                b = imem_byte(pc + 64'd1, bad);
                {r.reg_a, r.reg_b} = b;
                r.val_c = imem_quad(pc + 64'd2, bad);
                r.val_p = pc + 64'd10;
            end
            IC_JXX, IC_CALL: begin
                r.val_c = imem_quad(pc + 64'd1, bad);
                r.val_p = pc + 64'd9;
            end
            default: begin
                legal   = 1'b0;
                r.val_p = pc + 64'd1;
            end
        endcase
        if (bad) begin
            r.status = ST_ADR;
        end else if (!legal) begin
            r.status = ST_INS;
        end else if (r.icode == IC_HALT) begin
            r.status = ST_HLT;
        end else begin
            r.status = ST_AOK;
        end
        r.next_pred_pc = (r.icode == IC_JXX || r.icode == IC_CALL) ? r.val_c : r.val_p;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            pred_pc = '0;
            fetched_instrs.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (fetched_instrs.size() == 0) begin
                    $error("result with no fetch outstanding: fetch_pc %h", i_out.fetch_pc);
                    fails++;
                end else begin
                    want = fetched_instrs.pop_front();
                    check_field("fetch_pc", want.fetch_pc, i_out.fetch_pc);
                    check_field("icode", want.icode, i_out.icode);
                    if (want.status != ST_INS) begin
                        check_field("ifun", want.ifun, i_out.ifun);
                    end
                    check_field("reg_a", want.reg_a, i_out.reg_a);
                    check_field("reg_b", want.reg_b, i_out.reg_b);
                    check_field("val_c", want.val_c, i_out.val_c);
                    check_field("val_p", want.val_p, i_out.val_p);
                    check_field("status", want.status, i_out.status);
                    check_field("next_pred_pc", want.next_pred_pc, i_out.next_pred_pc);
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in.func == FN_LOAD) begin
                    if (i_in.load_addr < MEM_BYTES) begin
                        imem_copy[i_in.load_addr] = i_in.load_byte;
                    end
                end else begin
                    want = fetch_instr(i_in);
                    fetched_instrs.push_back(want);
                    pred_pc = want.next_pred_pc;
                end
            end
        end
        o_fail_count  <= fails;
        o_outstanding <= fetched_instrs.size();
    end

endmodule

/* sim/y86_pipeline_fetch_stage_tb.sv */
// Stimulus, flow control and verdict for the Y86-64 fetch stage testbench.
module y86_pipeline_fetch_stage_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import y86f_pkg::*;

    localparam int         MEM_BYTES    = 4096;
    localparam int         LIMIT        = 1_000_000;
    localparam int         RANDOM_ITEMS = 1600;
    localparam int         HOLD_CYCLES  = 300;
    localparam logic [3:0] IC_FIRST_BAD = 4'd12;
    localparam logic [3:0] IC_LAST_BAD  = 4'd15;

    typedef enum {
        PC_FOLLOW,
        PC_MISPREDICT,
        PC_RETURN,
        PC_BOTH
    } t_redirect;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    t_in  in_req;
    logic out_valid;
    logic out_ready;
    t_out out_res;
    int   fail_count;
    int   outstanding;
    int   items_sent  = 0;
    int   burst_left  = 0;
    bit   hold_req    = 1'b0;
    bit   hold_active = 1'b0;

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    y86_pipeline_fetch_stage #(
        .MEM_BYTES(MEM_BYTES)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in       (in_req),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out      (out_res)
    );

    y86_pipeline_fetch_stage_chk #(
        .MEM_BYTES(MEM_BYTES)
    ) u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_req),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_res),
        .o_fail_count (fail_count),
        .o_outstanding(outstanding)
    );

    function automatic t_in filler_req();
        t_in rq;
        rq.func      = FN_FETCH;
        rq.load_addr = 12'($urandom);
        rq.load_byte = 8'($urandom);
        rq.mem_icode = 4'($urandom);
        rq.mem_cond  = 1'($urandom);
        rq.mem_vala  = {$urandom, $urandom};
        rq.wb_icode  = 4'($urandom);
        rq.wb_valm   = {$urandom, $urandom};
        if (rq.mem_icode == IC_JXX) begin
            rq.mem_cond = 1'b1;
        end
        if (rq.wb_icode == IC_RET) begin
            rq.wb_icode = IC_NOP;
        end
        return rq;
    endfunction

    task automatic send(input t_in rq);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_req   <= rq;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic put_byte(input logic [63:0] addr, input logic [7:0] val);
        t_in rq;
        if (addr < 64'(MEM_BYTES)) begin
            rq           = filler_req();
            rq.func      = FN_LOAD;
            rq.load_addr = addr[11:0];
            rq.load_byte = val;
            send(rq);
        end
    endtask

    task automatic fetch_at(input logic [63:0] pc, input t_redirect how);
        t_in rq;
        rq = filler_req();
        case (how)
            PC_MISPREDICT: begin
                rq.mem_icode = IC_JXX;
                rq.mem_cond  = 1'b0;
                rq.mem_vala  = pc;
            end
            PC_RETURN: begin
                rq.wb_icode = IC_RET;
                rq.wb_valm  = pc;
            end
            PC_BOTH: begin
                rq.mem_icode = IC_JXX;
                rq.mem_cond  = 1'b0;
                rq.mem_vala  = pc;
                rq.wb_icode  = IC_RET;
            end
            default: ;
        endcase
        send(rq);
    endtask

    task automatic place_instr(input logic [63:0] at, input logic [3:0] ic,
                               input logic [63:0] k, output logic [63:0] nxt);
        logic [7:0] code [10];
        int         len;
        code[0] = {ic, 4'($urandom)};
        code[1] = 8'($urandom);
        if ($urandom_range(0, 3) == 0) begin
            code[1][7:4] = NO_REG;
        end
        if ($urandom_range(0, 3) == 0) begin
            code[1][3:0] = NO_REG;
        end
        case (ic)
            IC_RRMOV, IC_OPQ, IC_PUSH, IC_POP: begin
                len = 2;
            end
            IC_IRMOV, IC_RMMOV, IC_MRMOV: begin
                len = 10;
                for (int i = 0; i < 8; i++) code[2 + i] = k[8*i +: 8];
            end
            IC_JXX, IC_CALL: begin
                len = 9;
                for (int i = 0; i < 8; i++) code[1 + i] = k[8*i +: 8];
            end
            default: begin
                len = 1;
            end
        endcase
        for (int i = 0; i < len; i++) put_byte(at + 64'(i), code[i]);
        nxt = (ic == IC_JXX || ic == IC_CALL) ? k : at + 64'(len);
    endtask

    // Lay down a short program one instruction at a time and follow it.
    task automatic run_chain();
        logic [63:0] at;
        logic [63:0] k;
        logic [63:0] nxt;
        logic [3:0]  ic;
        t_redirect   how;
        int          pick;
        case ($urandom_range(0, 19))
            0:       at = '1 - 64'($urandom_range(0, 3));
            1:       at = {$urandom, $urandom};
            2, 3:    at = 64'($urandom_range(MEM_BYTES - 16, MEM_BYTES - 1));
            default: at = 64'($urandom_range(0, MEM_BYTES - 11));
        endcase
        how = t_redirect'($urandom_range(PC_MISPREDICT, PC_BOTH));
        repeat ($urandom_range(1, 8)) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                ic = IC_HALT;
            end else if (pick < 7) begin
                ic = 4'($urandom_range(IC_FIRST_BAD, IC_LAST_BAD));
            end else begin
                ic = 4'($urandom_range(IC_NOP, IC_POP));
            end
            if ((ic == IC_JXX || ic == IC_CALL) && $urandom_range(0, 7) != 0) begin
                k = 64'($urandom_range(0, MEM_BYTES - 1));
            end else begin
                k = {$urandom, $urandom};
            end
            place_instr(at, ic, k, nxt);
            fetch_at(at, how);
            how = PC_FOLLOW;
            at  = nxt;
        end
    endtask

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int mode;
        int span;
        out_ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (hold_req) begin
                out_ready  <= 1'b0;
                hold_active = 1'b1;
                for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
                hold_req    = 1'b0;
                hold_active = 1'b0;
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 120);
            repeat (span) begin
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 3) != 0);
                    2:       out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= ($urandom_range(0, 5) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    initial begin
        t_in         rq;
        logic [63:0] nxt;
        int          start;
        int          next_drain;
        int          pick;
        bit          pressed;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_req   <= '0;
        pressed   = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // fill every byte so no fetch can touch an unwritten location
        for (int a = 0; a < MEM_BYTES; a++) put_byte(64'(a), 8'($urandom));

        put_byte(64'd0, {IC_HALT, 4'h0});
        fetch_at(64'd0, PC_MISPREDICT);
        put_byte(64'd1, {IC_FIRST_BAD, 4'h3});
        fetch_at('0, PC_FOLLOW);
        put_byte(64'd2, {IC_RET, 4'h0});
        fetch_at('0, PC_FOLLOW);
        put_byte(64'(MEM_BYTES - 1), {IC_IRMOV, 4'h0});
        fetch_at(64'(MEM_BYTES - 1), PC_RETURN);
        fetch_at('1, PC_MISPREDICT);
        fetch_at('0, PC_FOLLOW);
        fetch_at(64'd2, PC_BOTH);
        fetch_at(64'(MEM_BYTES), PC_MISPREDICT);
        place_instr(64'd16, IC_JXX, 64'(MEM_BYTES - 2), nxt);
        fetch_at(64'd16, PC_MISPREDICT);
        fetch_at('0, PC_FOLLOW);
        drain_results();

        start      = items_sent;
        next_drain = 300;
        while (items_sent - start < RANDOM_ITEMS) begin
            if (!pressed && items_sent - start > RANDOM_ITEMS / 2) begin
                // hold the output long enough for the input to back up
                in_valid <= 1'b0;
                hold_req  = 1'b1;
                do @(posedge clk); while (!hold_active);
                repeat (12) fetch_at('0, PC_FOLLOW);
                drain_results();
                pressed = 1'b1;
            end else if (items_sent - start >= next_drain) begin
                drain_results();
                next_drain += 300;
            end
            pick = $urandom_range(0, 9);
            if (pick < 8) begin
                run_chain();
            end else if (pick == 8) begin
                rq           = filler_req();
                rq.mem_icode = 4'($urandom);
                rq.mem_cond  = 1'($urandom);
                rq.wb_icode  = 4'($urandom);
                if ($urandom_range(0, 1) == 0) begin
                    rq.mem_vala = 64'($urandom_range(0, MEM_BYTES - 1));
                end
                if ($urandom_range(0, 1) == 0) begin
                    rq.wb_valm = 64'($urandom_range(0, MEM_BYTES - 1));
                end
                send(rq);
            end else begin
                put_byte(64'($urandom_range(0, MEM_BYTES - 1)), 8'($urandom));
            end
        end
        drain_results();
        repeat (20) @(posedge clk);

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
